// ----- design/vps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vintage pixel stylizer package
// Payload types, register indexes and fixed-point widths shared by the block.
// ----------------------------------------------------------------------------
package vps_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_DESAT     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE_W    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE_RED  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE_GRN  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE_BLU  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VIGNETTE  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_W     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_H     = 4'd7;
  localparam int unsigned CFG_DATA_W = 13;

  // Field widths
  localparam int unsigned WGT_W  = 9;   // Q1.8 weight, 256 = one
  localparam int unsigned CH_W   = 8;
  localparam int unsigned POS_W  = 12;
  localparam int unsigned DIM_W  = 13;
  localparam int unsigned NUM_W  = 27;  // sum of two squared 13-bit distances
  localparam int unsigned LO_W   = 14;  // numerator bits shifted into the divider
  localparam int unsigned QUO_W  = 38;  // saturated Q24 distance ratio squared
  localparam int unsigned ROOT_W = 19;
  localparam int unsigned REM_W  = 21;
  localparam int unsigned LUMA_W = 24;
  localparam int unsigned DARK_W = 28;
  localparam int unsigned F_W    = 21;  // Q20 vignette factor
  localparam int unsigned C1_W   = 32;
  localparam int unsigned C2_W   = 40;
  localparam int unsigned PROD_W = 61;

  localparam logic [WGT_W-1:0] WGT_ONE = 9'd256;
  localparam logic [WGT_W-1:0] VIG_MIN = 9'd2;
  localparam logic [F_W-1:0]   F_ONE   = 21'h100000;

  // BT.601 luma weights in Q16
  localparam logic [15:0] LUMA_KR = 16'd19595;
  localparam logic [15:0] LUMA_KG = 16'd38470;
  localparam logic [15:0] LUMA_KB = 16'd7471;

  typedef struct packed {
    logic [CH_W-1:0]  pixel_blue;
    logic [CH_W-1:0]  pixel_green;
    logic [CH_W-1:0]  pixel_red;
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_red;
  } pix_out_t;

  // Channels in blue, green, red order
  typedef logic [2:0][CH_W-1:0] rgb_t;

  typedef struct packed {
    rgb_t             pix;
    logic             sat;
    logic [NUM_W-1:0] rem;
    logic [LO_W-1:0]  lo;
    logic [QUO_W-1:0] quo;
  } div_t;

  typedef struct packed {
    rgb_t              pix;
    logic              sat;
    logic [QUO_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqr_t;

endpackage

// ----- design/vintage_pixel_stylizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vintage pixel stylizer
// Desaturate, tone and vignette a BGR pixel stream, one pixel per free clock.
// ----------------------------------------------------------------------------
// A pixel is taken on every clock that out_stall_i leaves free. Most of the
// pipeline serves the vignette distance: a 38-stage restoring divider (one
// quotient bit a stage) forms the squared distance ratio and a 19-stage
// square root (one root bit a stage) follows it, with three address stages
// in front and five color stages behind. A stall on a valid output freezes
// the whole pipeline and is passed back on in_stall_o.
// Write the configuration registers only while no pixel is in flight.
// ----------------------------------------------------------------------------
module vintage_pixel_stylizer
  import vps_pkg::*;
#(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pix_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pix_out_t             out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Raw configuration registers
  logic [WGT_W-1:0] desat_q, tone_w_q, vig_w_q;
  logic [CH_W-1:0]  tone_r_q, tone_g_q, tone_b_q;
  logic [DIM_W-1:0] img_w_q, img_h_q;

  // Derived configuration
  logic [WGT_W-1:0] d_q, t_q, v_q;
  logic             vig_q;
  logic [DIM_W-1:0] w_sat, h_sat;
  logic [NUM_W-1:0] den_q;

  logic adv;

  assign cfg_ready_o = 1'b1;
  assign adv         = ~out_valid_o | ~out_stall_i;
  assign in_stall_o  = ~adv;

  // Take register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desat_q  <= 9'd77;
      tone_w_q <= 9'd102;
      tone_r_q <= 8'd210;
      tone_g_q <= 8'd180;
      tone_b_q <= 8'd120;
      vig_w_q  <= 9'd154;
      img_w_q  <= 13'd1920;
      img_h_q  <= 13'd1080;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DESAT:    desat_q  <= cfg_data_i[WGT_W-1:0];
        CFG_TONE_W:   tone_w_q <= cfg_data_i[WGT_W-1:0];
        CFG_TONE_RED: tone_r_q <= cfg_data_i[CH_W-1:0];
        CFG_TONE_GRN: tone_g_q <= cfg_data_i[CH_W-1:0];
        CFG_TONE_BLU: tone_b_q <= cfg_data_i[CH_W-1:0];
        CFG_VIGNETTE: vig_w_q  <= cfg_data_i[WGT_W-1:0];
        CFG_IMG_W:    img_w_q  <= cfg_data_i;
        CFG_IMG_H:    img_h_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Saturate image size, needed by the first pixel after a write
  always_comb begin
    if (img_w_q == '0)                    w_sat = DIM_W'(1);
    else if (32'(img_w_q) > MAX_DIM)      w_sat = DIM_W'(MAX_DIM);
    else                                  w_sat = img_w_q;
    if (img_h_q == '0)                    h_sat = DIM_W'(1);
    else if (32'(img_h_q) > MAX_DIM)      h_sat = DIM_W'(MAX_DIM);
    else                                  h_sat = img_h_q;
  end

  // Saturate weights, form the corner distance squared
  always_ff @(posedge clk_i) begin
    d_q   <= (desat_q  > WGT_ONE) ? WGT_ONE : desat_q;
    t_q   <= (tone_w_q > WGT_ONE) ? WGT_ONE : tone_w_q;
    v_q   <= (vig_w_q  > WGT_ONE) ? WGT_ONE : vig_w_q;
    vig_q <= (vig_w_q > VIG_MIN);
    den_q <= NUM_W'(w_sat * w_sat) + NUM_W'(h_sat * h_sat);
  end

  // ---------------- Stage A: distance from center ----------------
  logic             a_vld_q;
  rgb_t             a_pix_q;
  logic [DIM_W-1:0] a_dx_q, a_dy_q;
  logic [DIM_W-1:0] x2, y2;

  assign x2 = {in_data_i.column, 1'b0};
  assign y2 = {in_data_i.row, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_pix_q <= {in_data_i.pixel_red, in_data_i.pixel_green, in_data_i.pixel_blue};
      a_dx_q  <= (x2 > w_sat) ? x2 - w_sat : w_sat - x2;
      a_dy_q  <= (y2 > h_sat) ? y2 - h_sat : h_sat - y2;
    end
  end

  // ---------------- Stage B: squared distance ----------------
  logic             b_vld_q;
  rgb_t             b_pix_q;
  logic [NUM_W-1:0] b_num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (adv) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_pix_q <= a_pix_q;
      b_num_q <= NUM_W'(a_dx_q * a_dx_q) + NUM_W'(a_dy_q * a_dy_q);
    end
  end

  // ---------------- Stage C and divider ----------------
  // Quotient num * 2^24 / den, saturated once it reaches 2^QUO_W
  logic [QUO_W:0] div_vld_q;
  div_t           div_q [QUO_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_vld_q <= '0;
    end else if (adv) begin
      div_vld_q <= {div_vld_q[QUO_W-1:0], b_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_q[0].pix <= b_pix_q;
      div_q[0].sat <= ({14'b0, b_num_q} >= {den_q, 14'b0});
      div_q[0].rem <= NUM_W'(b_num_q[NUM_W-1:LO_W]);
      div_q[0].lo  <= b_num_q[LO_W-1:0];
      div_q[0].quo <= '0;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    logic             nb;
    logic [NUM_W:0]   trial;
    logic             ge;

    if (k < LO_W) begin : g_lo
      assign nb = div_q[k].lo[LO_W-1-k];
    end else begin : g_zero
      assign nb = 1'b0;
    end

    assign trial = {div_q[k].rem, nb};
    assign ge    = (trial >= {1'b0, den_q});

    // Advance one quotient bit
    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_q[k+1].pix <= div_q[k].pix;
        div_q[k+1].sat <= div_q[k].sat;
        div_q[k+1].lo  <= div_q[k].lo;
        div_q[k+1].rem <= ge ? NUM_W'(trial - {1'b0, den_q}) : NUM_W'(trial);
        div_q[k+1].quo <= {div_q[k].quo[QUO_W-2:0], ge};
      end
    end
  end

  // ---------------- Square root ----------------
  logic [ROOT_W-1:0] sq_vld_q;
  sqr_t              sq_q [ROOT_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= '0;
    end else if (adv) begin
      sq_vld_q <= {sq_vld_q[ROOT_W-2:0], div_vld_q[QUO_W]};
    end
  end

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqr
    sqr_t             cur;
    logic [REM_W+1:0] acc;
    logic [REM_W+1:0] trial;
    logic             ge;

    if (j == 0) begin : g_first
      always_comb begin
        cur.pix  = div_q[QUO_W].pix;
        cur.sat  = div_q[QUO_W].sat;
        cur.rad  = div_q[QUO_W].quo;
        cur.rem  = '0;
        cur.root = '0;
      end
    end else begin : g_next
      assign cur = sq_q[j-1];
    end

    assign acc   = {cur.rem, cur.rad[QUO_W-1-2*j -: 2]};
    assign trial = (REM_W+2)'({cur.root, 2'b01});
    assign ge    = (acc >= trial);

    // Advance one root bit
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_q[j].pix  <= cur.pix;
        sq_q[j].sat  <= cur.sat;
        sq_q[j].rad  <= cur.rad;
        sq_q[j].rem  <= ge ? REM_W'(acc - trial) : REM_W'(acc);
        sq_q[j].root <= {cur.root[ROOT_W-2:0], ge};
      end
    end
  end

  // ---------------- E1: luma and vignette factor ----------------
  logic              e1_vld_q;
  rgb_t              e1_pix_q;
  logic [LUMA_W-1:0] e1_luma_q;
  logic [F_W-1:0]    e1_f_q;
  logic [DARK_W-1:0] dark;
  sqr_t              sq_last;

  assign sq_last = sq_q[ROOT_W-1];
  assign dark    = DARK_W'(v_q * sq_last.root);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_vld_q <= 1'b0;
    end else if (adv) begin
      e1_vld_q <= sq_vld_q[ROOT_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_pix_q  <= sq_last.pix;
      e1_luma_q <= LUMA_W'(LUMA_KR * sq_last.pix[2]) + LUMA_W'(LUMA_KG * sq_last.pix[1])
                 + LUMA_W'(LUMA_KB * sq_last.pix[0]);
      if (!vig_q) begin
        e1_f_q <= F_ONE;
      end else if (sq_last.sat || (dark >= DARK_W'(F_ONE))) begin
        e1_f_q <= '0;
      end else begin
        e1_f_q <= F_ONE - F_W'(dark);
      end
    end
  end

  // ---------------- E2: blend toward luma ----------------
  logic                 e2_vld_q;
  logic [2:0][C1_W-1:0] e2_c1_q;
  logic [F_W-1:0]       e2_f_q;
  logic [2:0][C1_W-1:0] c1;

  always_comb begin
    logic signed [LUMA_W:0]   diff;
    logic signed [LUMA_W+10:0] prod;
    for (int k = 0; k < 3; k++) begin
      diff  = $signed({1'b0, e1_luma_q}) - $signed({1'b0, e1_pix_q[k], 16'b0});
      prod  = diff * $signed({1'b0, d_q});
      c1[k] = C1_W'($signed({3'b0, e1_pix_q[k], 24'b0}) + prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e2_vld_q <= 1'b0;
    end else if (adv) begin
      e2_vld_q <= e1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e2_c1_q <= c1;
      e2_f_q  <= e1_f_q;
    end
  end

  // ---------------- E3: blend toward tone ----------------
  logic                 e3_vld_q;
  logic [2:0][C2_W-1:0] e3_c2_q;
  logic [F_W-1:0]       e3_f_q;
  logic [2:0][C2_W-1:0] c2;
  rgb_t                 tone;

  assign tone = {tone_r_q, tone_g_q, tone_b_q};

  always_comb begin
    logic signed [C1_W:0]      diff;
    logic signed [C1_W+10:0]   prod;
    for (int k = 0; k < 3; k++) begin
      diff  = $signed({1'b0, tone[k], 24'b0}) - $signed({1'b0, e2_c1_q[k]});
      prod  = diff * $signed({1'b0, t_q});
      c2[k] = C2_W'($signed({3'b0, e2_c1_q[k], 8'b0}) + prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e3_vld_q <= 1'b0;
    end else if (adv) begin
      e3_vld_q <= e2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e3_c2_q <= c2;
      e3_f_q  <= e2_f_q;
    end
  end

  // ---------------- E4: apply vignette factor ----------------
  logic                   e4_vld_q;
  logic [2:0][PROD_W-1:0] e4_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e4_vld_q <= 1'b0;
    end else if (adv) begin
      e4_vld_q <= e3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        e4_prod_q[k] <= PROD_W'(e3_c2_q[k] * e3_f_q);
      end
    end
  end

  // ---------------- Output: round half up and clamp ----------------
  logic     out_vld_q;
  pix_out_t out_q;
  rgb_t     rnd;

  always_comb begin
    logic [PROD_W:0] sum;
    for (int k = 0; k < 3; k++) begin
      sum    = {1'b0, e4_prod_q[k]} + (PROD_W+1)'(64'd1 << 51);
      rnd[k] = (sum[PROD_W:52] > 10'd255) ? 8'd255 : sum[59:52];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= e4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.out_blue  <= rnd[0];
      out_q.out_green <= rnd[1];
      out_q.out_red   <= rnd[2];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // ---------------- Assertions ----------------
  // The root stage yields the exact floor square root of its radicand
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_vld_q[ROOT_W-1] |->
      ((40'(sq_last.root) * 40'(sq_last.root)) <= 40'(sq_last.rad)) &&
      ((40'(sq_last.root) + 40'd1) * (40'(sq_last.root) + 40'd1) > 40'(sq_last.rad)))
    else $error("square root stage result out of bounds");

  // With the vignette off the factor is exactly one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e1_vld_q && !vig_q) |-> (e1_f_q == F_ONE))
    else $error("vignette factor not unity while vignette is off");

  // A stall freezes the interior of the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> ($stable(div_vld_q) && $stable(sq_vld_q) && $stable(e4_prod_q)))
    else $error("pipeline moved during a stall");

endmodule
